[rtl/core/prdt_pkg.sv]
// Package for the prefix rule deduplicating table: rule record type, result
// codes, controller states, command/status structs and the rule match function.
// No dependencies.
package prdt_pkg;

    // Default number of rule slots.
    localparam int PRDT_TABLE_DEPTH = 64;

    // Input command codes.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Result codes.
    typedef enum logic [1:0] {
        STAT_ADDED = 2'd0,
        STAT_DUP   = 2'd1,
        STAT_FULL  = 2'd2
    } prdt_status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DECIDE,
        S_RESULT
    } prdt_state_t;

    // One stored rule, as held in a table slot.
    typedef struct packed {
        logic        has_asn;
        logic        has_prefix;
        logic        has_max_length;
        logic        is_ipv6;
        logic [31:0] asn;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [7:0]  pfx_len;
        logic [7:0]  max_length;
    } prdt_rule_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming rule and restart the scan index
        logic clear;  // empty the table
        logic issue;  // read the slot at the scan index and advance it
        logic write;  // store the captured rule in the next free slot
    } prdt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;       // no rule stored
        logic full;        // every slot holds a rule
        logic issue_last;  // scan index points at the last stored rule
        logic match;       // slot read last cycle matches the captured rule
    } prdt_stat_t;

    // Decide whether a stored rule matches a new one.
    function automatic logic prdt_match(input prdt_rule_t s, input prdt_rule_t r,
                                        input logic filter_mode);
        logic same_set;
        logic addr_eq;
        logic result;
        same_set = ({s.has_asn, s.has_prefix, s.has_max_length} ==
                    {r.has_asn, r.has_prefix, r.has_max_length});
        // IPv4 compares only the low 32 address bits.
        if (r.is_ipv6) begin
            addr_eq = (s.address_high == r.address_high) &&
                      (s.address_low == r.address_low);
        end else begin
            addr_eq = (s.address_low[31:0] == r.address_low[31:0]);
        end
        if (!same_set) begin
            if (!filter_mode) begin
                result = 1'b0;
            end else if (s.has_asn && r.has_asn) begin
                result = (s.asn == r.asn);
            end else if (s.has_prefix && r.has_prefix && (s.is_ipv6 == r.is_ipv6) &&
                         (s.pfx_len == r.pfx_len)) begin
                result = addr_eq;
            end else begin
                result = 1'b0;
            end
        end else begin
            result = !(s.has_asn && (s.asn != r.asn)) &&
                     !(s.has_prefix && ((s.pfx_len != r.pfx_len) ||
                                        (s.is_ipv6 != r.is_ipv6) || !addr_eq)) &&
                     !(s.has_max_length && (s.max_length != r.max_length));
        end
        return result;
    endfunction

endpackage

[rtl/core/prdt_datapath.sv]
// Datapath of the prefix rule deduplicating table: rule memory, fill count,
// scan index, captured rule and match logic. Depends on prdt_pkg.
module prdt_datapath
    import prdt_pkg::*;
#(
    parameter int TABLE_DEPTH = PRDT_TABLE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  prdt_rule_t in_rule,
    input  prdt_cmd_t  cmd,
    output prdt_stat_t stat
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Slots are filled from the bottom and only emptied all at once, so the
    // valid slots are always slots 0 up to the fill count minus one.
    prdt_rule_t             mem [TABLE_DEPTH];
    prdt_rule_t             rd_data_reg;
    prdt_rule_t             item_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   rd_vld_reg;
    logic                   filter_mode_reg;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            filter_mode_reg <= cfg_wr_data;
        end
    end

    // Captured rule of the transaction in progress.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= in_rule;
        end
    end

    // Fill count, scan index and read-data valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.issue;
            if (cmd.clear) begin
                count_reg <= '0;
            end else if (cmd.write) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.load) begin
                idx_reg <= '0;
            end else if (cmd.issue) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Rule memory: one write port at the fill count, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem[count_reg[IDX_W-1:0]] <= item_reg;
        end
        if (cmd.issue) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Status towards the controller.
    always_comb begin
        stat.empty      = (count_reg == '0);
        stat.full       = (count_reg == CNT_W'(TABLE_DEPTH));
        stat.issue_last = ((CNT_W'(idx_reg) + 1'b1) == count_reg);
        stat.match      = rd_vld_reg && prdt_match(rd_data_reg, item_reg, filter_mode_reg);
    end

endmodule

[rtl/core/prdt_ctrl.sv]
// Controller of the prefix rule deduplicating table: transaction handshakes,
// scan sequencing and the result register. Depends on prdt_pkg.
module prdt_ctrl
    import prdt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    input  prdt_stat_t stat,
    output prdt_cmd_t  cmd
);

    prdt_state_t  state_reg, state_next;
    prdt_status_t res_reg, res_next;
    prdt_status_t m_status_reg, m_status_next;
    logic         m_valid_reg, m_valid_next;

    // State and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg      <= res_next;
        m_status_reg <= m_status_next;
    end

    // Next state, commands and result hand-over.
    always_comb begin
        state_next    = state_reg;
        res_next      = res_reg;
        m_status_next = m_status_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd           = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_command == CMD_CLEAR) begin
                        cmd.clear  = 1'b1;
                        res_next   = STAT_ADDED;
                        state_next = S_RESULT;
                    end else if (stat.empty) begin
                        state_next = S_DECIDE;
                    end else begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                // One slot read per cycle; a hit ends the scan early.
                cmd.issue = 1'b1;
                if (stat.match) begin
                    res_next   = STAT_DUP;
                    state_next = S_RESULT;
                end else if (stat.issue_last) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // The last slot read is checked here before the rule is stored.
                if (stat.match) begin
                    res_next = STAT_DUP;
                end else if (stat.full) begin
                    res_next = STAT_FULL;
                end else begin
                    cmd.write = 1'b1;
                    res_next  = STAT_ADDED;
                end
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

    // A scan never starts on an empty table.
    a_issue_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ISSUE) |-> !stat.empty)
        else $error("slot scan running on an empty table");

    // A rule is never stored into a full table.
    a_write_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |-> !stat.full)
        else $error("rule written into a full table");

    // Reading and writing the memory never coincide.
    a_issue_write_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> !cmd.write)
        else $error("slot read and write in the same cycle");

    // Only one transaction is in progress at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new transaction accepted while one is in progress");

endmodule

[rtl/core/prefix_rule_dedup_table_unit.sv]
// Top level of the prefix rule deduplicating table.
// Depends on prdt_pkg, prdt_ctrl and prdt_datapath.
//
// Stores route-origin prefix rules and adds a new rule only when no stored
// rule matches it and a slot is free; a clear transaction empties the table
// at once. Items are handled one at a time: an add scans the stored rules
// before its result reaches the result register, because the table memory
// has one read port and the scan compares one stored rule per cycle,
// stopping at the first match; the next item is accepted once the result
// register is loaded. A clear goes straight to the result state with no
// scan. The next item can be accepted while a result still waits in the
// output register; only the following result waits for it to be taken.
// There is no clearing pass after reset: the fill count alone marks which
// slots hold rules. filter_mode must only be written while the block is idle.
module prefix_rule_dedup_table_unit
    import prdt_pkg::*;
#(
    parameter int TABLE_DEPTH = PRDT_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic        s_has_asn,
    input  logic        s_has_prefix,
    input  logic        s_has_max_length,
    input  logic [31:0] s_asn,
    input  logic        s_is_ipv6,
    input  logic [63:0] s_address_high,
    input  logic [63:0] s_address_low,
    input  logic [7:0]  s_pfx_len,
    input  logic [7:0]  s_max_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status
);

    prdt_rule_t in_rule;
    prdt_cmd_t  cmd;
    prdt_stat_t stat;

    // Gather the incoming rule fields into one record.
    always_comb begin
        in_rule.has_asn        = s_has_asn;
        in_rule.has_prefix     = s_has_prefix;
        in_rule.has_max_length = s_has_max_length;
        in_rule.is_ipv6        = s_is_ipv6;
        in_rule.asn            = s_asn;
        in_rule.address_high   = s_address_high;
        in_rule.address_low    = s_address_low;
        in_rule.pfx_len        = s_pfx_len;
        in_rule.max_length     = s_max_length;
    end

    prdt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .stat      (stat),
        .cmd       (cmd)
    );

    prdt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_rule     (in_rule),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

[bench/prefix_rule_dedup_table_unit_tb.sv]
// Self-checking testbench for prefix_rule_dedup_table_unit: a directed table, then random
// rule traffic under several idling patterns, each status checked against a shadow table.
// Depends on prdt_pkg and the prefix_rule_dedup_table_unit RTL.
`timescale 1ns / 100ps

module prefix_rule_dedup_table_unit_tb;
    import prdt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 145;
    localparam int PHASE_COUNT    = 6;

    // One row of the directed stimulus table.
    typedef struct {
        logic         mode;
        logic         cmd;
        prdt_rule_t   rule;
        bit           typed;
        prdt_status_t status;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = CMD_ADD;
    logic        s_has_asn = 1'b0;
    logic        s_has_prefix = 1'b0;
    logic        s_has_max_length = 1'b0;
    logic [31:0] s_asn = '0;
    logic        s_is_ipv6 = 1'b0;
    logic [63:0] s_address_high = '0;
    logic [63:0] s_address_low = '0;
    logic [7:0]  s_pfx_len = '0;
    logic [7:0]  s_max_length = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;

    // Shadow copy of the rule table and of the mode register.
    prdt_rule_t shadow_rule [PRDT_TABLE_DEPTH];
    bit         shadow_used [PRDT_TABLE_DEPTH];
    logic       shadow_filter = 1'b0;

    prdt_status_t  status_due [$];
    prdt_rule_t    recent_rules [$];
    directed_row_t directed_rows [$];

    int mismatch_count = 0;
    int send_idle_pct = 36;
    int recv_idle_pct = 87;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    int phase_send_pct [PHASE_COUNT] = '{36, 36, 87, 87, 0, 0};
    int phase_recv_pct [PHASE_COUNT] = '{87, 87, 36, 36, 0, 0};
    bit phase_mode     [PHASE_COUNT] = '{0, 1, 1, 0, 1, 0};

    prefix_rule_dedup_table_unit #(
        .TABLE_DEPTH(PRDT_TABLE_DEPTH)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_has_asn       (s_has_asn),
        .s_has_prefix    (s_has_prefix),
        .s_has_max_length(s_has_max_length),
        .s_asn           (s_asn),
        .s_is_ipv6       (s_is_ipv6),
        .s_address_high  (s_address_high),
        .s_address_low   (s_address_low),
        .s_pfx_len       (s_pfx_len),
        .s_max_length    (s_max_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status)
    );

    always #4 aclk = ~aclk;

    // Decide whether a stored rule and a new rule describe the same thing.
    function automatic bit rules_collide(input prdt_rule_t held, input prdt_rule_t fresh);
        bit family_same;
        bit length_same;
        bit addr_same;
        family_same = (held.is_ipv6 == fresh.is_ipv6);
        length_same = (held.pfx_len == fresh.pfx_len);
        // IPv4 addresses live in the low 32 bits only.
        if (fresh.is_ipv6) begin
            addr_same = ({held.address_high, held.address_low} ==
                         {fresh.address_high, fresh.address_low});
        end else begin
            addr_same = (held.address_low[31:0] == fresh.address_low[31:0]);
        end
        if ({held.has_asn, held.has_prefix, held.has_max_length} !=
            {fresh.has_asn, fresh.has_prefix, fresh.has_max_length}) begin
            if (!shadow_filter) begin
                return 1'b0;
            end
            if (held.has_asn && fresh.has_asn) begin
                return held.asn == fresh.asn;
            end
            if (held.has_prefix && fresh.has_prefix && family_same && length_same) begin
                return addr_same;
            end
            return 1'b0;
        end
        if (held.has_asn && (held.asn != fresh.asn)) begin
            return 1'b0;
        end
        if (held.has_prefix && !(family_same && length_same && addr_same)) begin
            return 1'b0;
        end
        if (held.has_max_length && (held.max_length != fresh.max_length)) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one transaction to the shadow table and return the status it earns.
    function automatic prdt_status_t dedup_status(input logic cmd, input prdt_rule_t rule);
        int free_idx;
        free_idx = -1;
        if (cmd == CMD_CLEAR) begin
            foreach (shadow_used[i]) begin
                shadow_used[i] = 1'b0;
            end
            return STAT_ADDED;
        end
        // Scan in slot order: the first match wins, the lowest free slot takes the rule.
        for (int i = 0; i < PRDT_TABLE_DEPTH; i++) begin
            if (shadow_used[i]) begin
                if (rules_collide(shadow_rule[i], rule)) begin
                    return STAT_DUP;
                end
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (free_idx < 0) begin
            return STAT_FULL;
        end
        shadow_used[free_idx] = 1'b1;
        shadow_rule[free_idx] = rule;
        return STAT_ADDED;
    endfunction

    function automatic directed_row_t directed_entry(
        input logic mode, input logic cmd, input logic [2:0] flags, input logic v6,
        input logic [31:0] asn, input logic [63:0] hi, input logic [63:0] lo,
        input logic [7:0] plen, input logic [7:0] mlen,
        input bit typed, input prdt_status_t status);
        directed_row_t row;
        row.mode = mode;
        row.cmd = cmd;
        {row.rule.has_asn, row.rule.has_prefix, row.rule.has_max_length} = flags;
        row.rule.is_ipv6 = v6;
        row.rule.asn = asn;
        row.rule.address_high = hi;
        row.rule.address_low = lo;
        row.rule.pfx_len = plen;
        row.rule.max_length = mlen;
        row.typed = typed;
        row.status = status;
        return row;
    endfunction

    // Favour the lengths that real rules use, with the odd value above 128.
    function automatic logic [7:0] pick_length();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd128;
            2: return 8'd32;
            3: return 8'd24;
            4: return 8'($urandom_range(0, 128));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random rule; small value spaces keep collisions frequent.
    function automatic prdt_rule_t fresh_rule();
        prdt_rule_t rule;
        rule.has_asn = 1'($urandom_range(0, 1));
        rule.has_prefix = 1'($urandom_range(0, 1));
        rule.has_max_length = 1'($urandom_range(0, 1));
        rule.is_ipv6 = 1'($urandom_range(0, 1));
        rule.asn = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 15));
        rule.address_high = {$urandom, $urandom};
        if ($urandom_range(0, 1)) begin
            rule.address_low = {$urandom, $urandom};
        end else begin
            rule.address_low = {$urandom, 28'd0, 4'($urandom_range(0, 15))};
        end
        rule.pfx_len = pick_length();
        rule.max_length = pick_length();
        return rule;
    endfunction

    // Near miss of an earlier rule: one flag or one field changed.
    function automatic prdt_rule_t mutate_rule(input prdt_rule_t rule);
        prdt_rule_t alt;
        alt = rule;
        case ($urandom_range(0, 8))
            0: alt.has_asn = ~alt.has_asn;
            1: alt.has_prefix = ~alt.has_prefix;
            2: alt.has_max_length = ~alt.has_max_length;
            3: alt.is_ipv6 = ~alt.is_ipv6;
            4: alt.asn = alt.asn ^ (32'd1 << $urandom_range(0, 31));
            5: alt.address_low = alt.address_low ^ (64'd1 << $urandom_range(0, 63));
            6: alt.address_high = alt.address_high ^ (64'd1 << $urandom_range(0, 63));
            7: alt.pfx_len = 8'($urandom_range(0, 255));
            default: alt.max_length = 8'($urandom_range(0, 255));
        endcase
        return alt;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Present one transaction, wait for acceptance and record the status it should earn.
    task automatic offer(input logic cmd, input prdt_rule_t rule, input bit typed,
                         input prdt_status_t typed_status);
        prdt_status_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_has_asn <= rule.has_asn;
        s_has_prefix <= rule.has_prefix;
        s_has_max_length <= rule.has_max_length;
        s_asn <= rule.asn;
        s_is_ipv6 <= rule.is_ipv6;
        s_address_high <= rule.address_high;
        s_address_low <= rule.address_low;
        s_pfx_len <= rule.pfx_len;
        s_max_length <= rule.max_length;
        do @(posedge aclk); while (!s_ready);
        predicted = dedup_status(cmd, rule);
        status_due.push_back(typed ? typed_status : predicted);
    endtask

    // Stop offering and let every outstanding result come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (status_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // The mode register may only change while the block is idle.
    task automatic set_filter_mode(input logic mode);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        shadow_filter = mode;
    endtask

    task automatic run_random(input int count, input bit with_hold, input bit with_pause);
        prdt_rule_t  rule;
        int          pick;
        logic [15:0] tag;
        for (int k = 0; k < count; k++) begin
            if (with_hold && (k == 20)) begin
                hold_token++;
            end
            if (with_pause && (k == 60)) begin
                drain_results();
            end
            // Fill burst: a clear, then distinct AS rules until the table overflows.
            if (k == 40) begin
                offer(CMD_CLEAR, fresh_rule(), 1'b1, STAT_ADDED);
                tag = 16'($urandom);
                for (int j = 0; j < PRDT_TABLE_DEPTH + 6; j++) begin
                    rule = fresh_rule();
                    rule.has_asn = 1'b1;
                    rule.asn = {tag, 16'(j)};
                    offer(CMD_ADD, rule, 1'b0, STAT_ADDED);
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                offer(CMD_CLEAR, fresh_rule(), 1'b1, STAT_ADDED);
            end else begin
                if ((pick < 40) && (recent_rules.size() != 0)) begin
                    rule = recent_rules[$urandom_range(0, recent_rules.size() - 1)];
                end else if ((pick < 65) && (recent_rules.size() != 0)) begin
                    rule = mutate_rule(recent_rules[$urandom_range(0, recent_rules.size() - 1)]);
                end else begin
                    rule = fresh_rule();
                end
                offer(CMD_ADD, rule, 1'b0, STAT_ADDED);
                recent_rules.push_back(rule);
                if (recent_rules.size() > 24) begin
                    void'(recent_rules.pop_front());
                end
            end
        end
    endtask

    task automatic check_status(input logic [1:0] got);
        prdt_status_t want;
        if (status_due.size() == 0) begin
            report_mismatch($sformatf("status %0d with no transaction outstanding", got));
        end else begin
            want = status_due.pop_front();
            if (got !== want) begin
                report_mismatch($sformatf("status %0d, expected %0d (%s)", got, want,
                                          want.name()));
            end
        end
    endtask

    // Result side: check each accepted transaction, then choose the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_status(m_status);
        end
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: too long without any transaction on either channel ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        foreach (shadow_used[i]) begin
            shadow_used[i] = 1'b0;
        end

        // Directed table. Assertion mode first, then filter mode over the same contents.
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b100, 1'b0, 32'hFFFF_FFFF,
                                               '0, '0, 8'd0, 8'd0, 1'b1, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b100, 1'b0, 32'hFFFF_FFFF,
                                               '0, '0, 8'd0, 8'd0, 1'b1, STAT_DUP));
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b100, 1'b1, 32'h0, '1, '1,
                                               8'hFF, 8'hFF, 1'b1, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b010, 1'b0, 32'h1, '1,
                                               64'hFFFF_FFFF_0A00_0000, 8'd8, 8'd0,
                                               1'b1, STAT_ADDED));
        // IPv4 ignores the upper address bits.
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b010, 1'b0, 32'h2, '0,
                                               64'h1234_5678_0A00_0000, 8'd8, 8'd9,
                                               1'b1, STAT_DUP));
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b010, 1'b1, 32'h0, '1, '1,
                                               8'd128, 8'd0, 1'b0, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b010, 1'b1, 32'h0, '1,
                                               64'hFFFF_FFFF_FFFF_FFFE, 8'd128, 8'd0,
                                               1'b0, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b111, 1'b0, 32'd65000, '0,
                                               64'h0000_0000_C0A8_0100, 8'd24, 8'd32,
                                               1'b0, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b111, 1'b0, 32'd65000, '0,
                                               64'h0000_0000_C0A8_0100, 8'd24, 8'd255,
                                               1'b0, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b100, 1'b0, 32'd65000, '0,
                                               '0, 8'd0, 8'd0, 1'b0, STAT_ADDED));
        // Rules with no fields present all match one another.
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b000, 1'b1, 32'h5555_AAAA,
                                               64'h0123_4567_89AB_CDEF, '1, 8'd77, 8'd200,
                                               1'b0, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b000, 1'b0, 32'h0, '0, '0,
                                               8'd0, 8'd0, 1'b0, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b001, 1'b0, 32'h0, '0, '0,
                                               8'd0, 8'd128, 1'b0, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b0, CMD_ADD, 3'b010, 1'b0, 32'h0, '0, '0,
                                               8'd200, 8'd0, 1'b0, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b1, CMD_ADD, 3'b110, 1'b1, 32'd65000, '0,
                                               '0, 8'd64, 8'd0, 1'b0, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b1, CMD_ADD, 3'b010, 1'b0, 32'h0, '0,
                                               64'h0000_0000_C0A8_0100, 8'd24, 8'd0,
                                               1'b0, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b1, CMD_ADD, 3'b011, 1'b1, 32'h0, '1, '1,
                                               8'd128, 8'd0, 1'b0, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b1, CMD_CLEAR, 3'b111, 1'b1, 32'h0, '1, '1,
                                               8'hFF, 8'hFF, 1'b1, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b1, CMD_ADD, 3'b100, 1'b0, 32'hFFFF_FFFF,
                                               '0, '0, 8'd0, 8'd0, 1'b1, STAT_ADDED));
        directed_rows.push_back(directed_entry(1'b1, CMD_ADD, 3'b100, 1'b0, 32'hFFFF_FFFF,
                                               '0, '0, 8'd0, 8'd0, 1'b1, STAT_DUP));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].mode != shadow_filter) begin
                set_filter_mode(directed_rows[i].mode);
            end
            offer(directed_rows[i].cmd, directed_rows[i].rule, directed_rows[i].typed,
                  directed_rows[i].status);
        end

        // Random phases: each idling pattern under both table modes.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            set_filter_mode(phase_mode[ph]);
            send_idle_pct = phase_send_pct[ph];
            recv_idle_pct = phase_recv_pct[ph];
            run_random(PHASE_ITEMS, ph == 4, ph == 2);
        end

        drain_results();
        repeat (80) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
